// ===== src/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared widths, configuration types and pin rotation helpers for the
// capacitive scan decimator.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int CHANNELS   = 4;
  localparam int MAX_PINS   = 32;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 16;
  localparam int CAP_W      = 20;
  localparam int PIN_W      = 5;
  localparam int GPIO_W     = 6;
  localparam int OSR_W      = 5;
  localparam int MCC_W      = 16;
  localparam int PCNT_W     = 6;
  localparam int MAX_SHIFT  = 4;
  localparam int SHIFT_W    = 4;
  localparam int OSR_MIN    = 4;
  localparam int OSR_MAX    = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = CHANNELS * SAMPLE_W;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERSAMPLE_LOG2  = 2'd0,
    CFG_MAX_CHARGE_COUNT = 2'd1,
    CFG_SENSE_PIN_COUNT  = 2'd2,
    CFG_SENSE_PIN_BASE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [OSR_W-1:0]  oversample_log2;
    logic [MCC_W-1:0]  max_charge_count;
    logic [PCNT_W-1:0] sense_pin_count;
    logic [PIN_W-1:0]  sense_pin_base;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    oversample_log2:  OSR_W'(8),
    max_charge_count: MCC_W'(255),
    sense_pin_count:  PCNT_W'(4),
    sense_pin_base:   PIN_W'(0)
  };

  typedef struct packed {
    logic [CNT_W-1:0]                 count;
    logic [CHANNELS-1:0][SUM_W-1:0]   sums;
  } sum_row_t;

  typedef struct packed {
    logic [CHANNELS-1:0][SUM_W-1:0] sums;
  } acc_batch_t;

  typedef struct packed {
    logic [CHANNELS-1:0][PIN_W-1:0]  pins;
    logic [CHANNELS-1:0][CAP_W-1:0]  caps;
    logic [CHANNELS-1:0][GPIO_W-1:0] gpio;
  } res_batch_t;

  function automatic logic [OSR_W-1:0] eff_log2(input logic [OSR_W-1:0] v);
    logic [OSR_W-1:0] r;
    r = v;
    if (v < OSR_W'(OSR_MIN)) r = OSR_W'(OSR_MIN);
    if (v > OSR_W'(OSR_MAX)) r = OSR_W'(OSR_MAX);
    return r;
  endfunction

  function automatic logic [PCNT_W-1:0] eff_count(input logic [PCNT_W-1:0] v);
    logic [PCNT_W-1:0] r;
    r = v;
    if (v == '0) r = PCNT_W'(1);
    if (v > PCNT_W'(MAX_PINS)) r = PCNT_W'(MAX_PINS);
    return r;
  endfunction

  function automatic logic [PIN_W-1:0] next_pin(input logic [PIN_W-1:0] p,
                                                 input logic [PCNT_W-1:0] cnt);
    logic [PIN_W-1:0] r;
    r = p + PIN_W'(1);
    if ({1'b0, p} >= cnt - PCNT_W'(1)) r = '0;
    return r;
  endfunction

endpackage

// ===== src/csd_accum.sv =====
// ----------------------------------------------------------------------------
// csd_accum
// Channel sum memory with read-modify-write update and batch end detection.
// ----------------------------------------------------------------------------
module csd_accum (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  logic [csd_pkg::CHANNELS-1:0][csd_pkg::SAMPLE_W-1:0] in_samples,
  input  csd_pkg::cfg_t                               cfg,
  output logic                                        batch_valid,
  output csd_pkg::acc_batch_t                         batch
);
  import csd_pkg::*;

  sum_row_t sum_mem [1];
  sum_row_t rd_row;
  sum_row_t fwd_row;
  sum_row_t cur_row;
  sum_row_t wr_row;

  logic                             s1_valid;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] s1_samples;
  logic                             mem_valid;
  logic                             rd_valid;
  logic                             fwd_valid;

  logic [CHANNELS-1:0][SUM_W-1:0] sums_new;
  logic [CNT_W-1:0]               batch_lim;
  logic                           batch_end;

  always_ff @(posedge clk) begin
    rd_row <= sum_mem[0];
    if (s1_valid) begin
      sum_mem[0] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      mem_valid   <= 1'b0;
      rd_valid    <= 1'b0;
      fwd_valid   <= 1'b0;
      batch_valid <= 1'b0;
    end else begin
      s1_valid    <= in_valid;
      rd_valid    <= mem_valid;
      fwd_valid   <= s1_valid;
      batch_valid <= s1_valid && batch_end;
      if (s1_valid) begin
        mem_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_samples <= in_samples;
    fwd_row    <= wr_row;
    batch.sums <= sums_new;
  end

  always_comb begin
    if (fwd_valid) begin
      cur_row = fwd_row;
    end else if (rd_valid) begin
      cur_row = rd_row;
    end else begin
      cur_row = '0;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      sums_new[i] = cur_row.sums[i] + SUM_W'(s1_samples[i]);
    end
    batch_lim = CNT_W'((17'(1) << eff_log2(cfg.oversample_log2)) - 17'(1));
    batch_end = cur_row.count >= batch_lim;
    if (batch_end) begin
      wr_row = '0;
    end else begin
      wr_row.count = cur_row.count + CNT_W'(1);
      wr_row.sums  = sums_new;
    end
  end

endmodule

// ===== src/csd_reduce.sv =====
// ----------------------------------------------------------------------------
// csd_reduce
// Turns finished channel sums into readings and rotates the sensing pins.
// ----------------------------------------------------------------------------
module csd_reduce (
  input  logic                clk,
  input  logic                rst,
  input  logic                batch_valid,
  input  csd_pkg::acc_batch_t batch,
  input  csd_pkg::cfg_t       cfg,
  output logic                res_valid,
  output csd_pkg::res_batch_t res
);
  import csd_pkg::*;

  logic [PIN_W-1:0]   active_pin;
  logic [PIN_W-1:0]   active_pin_next;
  logic [PCNT_W-1:0]  pin_cnt;
  logic [SHIFT_W-1:0] shift;
  logic [SUM_W-1:0]   top;
  logic [SUM_W-1:0]   sub;
  logic [PIN_W-1:0]   p;
  res_batch_t         res_next;

  always_comb begin
    pin_cnt = eff_count(cfg.sense_pin_count);
    shift   = SHIFT_W'(eff_log2(cfg.oversample_log2) - OSR_W'(MAX_SHIFT));
    top     = SUM_W'({cfg.max_charge_count, 4'b0000});
    sub     = '0;
    p       = active_pin;
    for (int i = 0; i < CHANNELS; i++) begin
      sub = batch.sums[i] >> shift;
      res_next.caps[i] = (sub > top) ? '0 : CAP_W'(top - sub);
      res_next.pins[i] = p;
      p = next_pin(p, pin_cnt);
    end
    active_pin_next = p;
    for (int i = 0; i < CHANNELS; i++) begin
      res_next.gpio[i] = GPIO_W'(p) + GPIO_W'(cfg.sense_pin_base);
      p = next_pin(p, pin_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_pin <= '0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= batch_valid;
      if (batch_valid) begin
        active_pin <= active_pin_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// ===== src/csd_queue.sv =====
// ----------------------------------------------------------------------------
// csd_queue
// Result batch memory and serializer that sends one reading per word.
// ----------------------------------------------------------------------------
module csd_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_valid,
  input  csd_pkg::res_batch_t                 wr_batch,
  output logic                                space,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csd_pkg::OUT_DATA_W-1:0]      out_data,
  output logic                                out_last
);
  import csd_pkg::*;

  res_batch_t bq_mem [QUEUE_DEPTH];
  res_batch_t rd_data;
  res_batch_t ob;

  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              ob_valid;
  logic              ld_pend;
  logic [1:0]        sel;
  logic              done;

  assign space     = count < QCNT_W'(QUEUE_DEPTH);
  assign out_valid = ob_valid;
  assign out_last  = sel == 2'(CHANNELS - 1);
  assign done      = ob_valid && out_ready && out_last;
  assign out_data  = OUT_DATA_W'({ob.gpio, ob.caps[sel], ob.pins[sel]});

  always_comb begin
    count_next = count;
    if (wr_valid) count_next = count_next + QCNT_W'(1);
    if (done)     count_next = count_next - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    rd_data <= bq_mem[rd_ptr];
    if (wr_valid) begin
      bq_mem[wr_ptr] <= wr_batch;
    end
    if (ld_pend) begin
      ob <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      ob_valid <= 1'b0;
      ld_pend  <= 1'b0;
      sel      <= '0;
    end else begin
      count <= count_next;
      if (wr_valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (ld_pend) begin
        ob_valid <= 1'b1;
        ld_pend  <= 1'b0;
        sel      <= '0;
      end else if (!ob_valid && count != '0) begin
        ld_pend <= 1'b1;
      end
      if (done) begin
        ob_valid <= 1'b0;
        rd_ptr   <= rd_ptr + QPTR_W'(1);
      end else if (ob_valid && out_ready) begin
        sel <= sel + 2'd1;
      end
    end
  end

endmodule

// ===== src/capacitive_scan_decimator.sv =====
// ----------------------------------------------------------------------------
// capacitive_scan_decimator
// Accumulate-and-dump decimator for a four-channel capacitive sensing scan.
// ----------------------------------------------------------------------------
// Takes one input word per clock, sustained. Words flagged fifo_empty are
// dropped. The four channel sums and the sample count sit in one row of a
// synchronous memory that is read every cycle and updated and written back
// for each kept word, with the last write forwarded to the next word. Once
// 2^oversample_log2 words are summed (exponent clamped to 4..16), the batch
// goes through a reading stage into a four-entry result queue, and four
// result words leave in channel order, one per cycle while the receiver is
// ready. Input stalls only when the result queue holds four batches.
// Configuration writes are registered and should be made while the block is idle.
// ----------------------------------------------------------------------------
module capacitive_scan_decimator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [csd_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [csd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample_a, sample_b, sample_c, sample_d
  input  logic [csd_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // fifo_empty
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // pin_index, cap_value, next_gpio_a, next_gpio_b, next_gpio_c,
  // next_gpio_d, zero fill
  output logic [csd_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import csd_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic       batch_valid;
  acc_batch_t batch;
  logic       res_valid;
  res_batch_t res;

  logic [CHANNELS-1:0][SAMPLE_W-1:0] in_samples;

  assign in_valid   = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
  assign in_samples = s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_OVERSAMPLE_LOG2:  cfg.oversample_log2  <= OSR_W'(cfg_wdata);
        CFG_MAX_CHARGE_COUNT: cfg.max_charge_count <= MCC_W'(cfg_wdata);
        CFG_SENSE_PIN_COUNT:  cfg.sense_pin_count  <= PCNT_W'(cfg_wdata);
        CFG_SENSE_PIN_BASE:   cfg.sense_pin_base   <= PIN_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  csd_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_samples  (in_samples),
    .cfg         (cfg),
    .batch_valid (batch_valid),
    .batch       (batch)
  );

  csd_reduce u_reduce (
    .clk         (clk),
    .rst         (rst),
    .batch_valid (batch_valid),
    .batch       (batch),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  csd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (res_valid),
    .wr_batch  (res),
    .space     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== src/csd_checker.sv =====
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks for the capacitive scan decimator, bound to the top level.
// ----------------------------------------------------------------------------
module csd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic [csd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input logic [csd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [csd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [csd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);
  import csd_pkg::*;

  localparam int GPIO_LO = PIN_W + CAP_W;
  localparam int GPIO_HI = GPIO_LO + CHANNELS * GPIO_W - 1;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  a_gpio_batch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[GPIO_HI:GPIO_LO] == $past(m_axis_tdata[GPIO_HI:GPIO_LO]))
    else $error("next GPIO set changed inside a batch");

  a_batch_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("batch not closed after its last word");

endmodule

bind capacitive_scan_decimator csd_checker u_csd_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the capacitive scan decimator. A table of directed
// runs covers reset settings, dropped words, register clamping, zero and
// full-scale readings, a shrinking pin rotation and a batch cut short by a
// lower oversampling. Random phases with random settings and random idling
// on both streams follow. Every result word is compared with a bench-side
// accumulate-and-dump model of the scan.
// ----------------------------------------------------------------------------
module tb_top;
  import csd_pkg::*;

  localparam int RAND_WORDS    = 210;
  localparam int SETTLE_CYCLES = 16;
  localparam int RX_HOLD_CYCLES = 150;

  typedef struct {
    logic [4:0]  pin;
    logic [19:0] cap;
    logic        last;
    logic [5:0]  ga;
    logic [5:0]  gb;
    logic [5:0]  gc;
    logic [5:0]  gd;
  } reading_t;

  typedef struct {
    logic [4:0]  osr;
    logic [15:0] mcc;
    logic [5:0]  pcnt;
    logic [4:0]  base;
    logic        empty;
    logic [15:0] sa;
    logic [15:0] sb;
    logic [15:0] sc;
    logic [15:0] sd;
    int          count;
    bit          burst;
    bit          has_cap;
    logic [19:0] cap;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_addr = CFG_OVERSAMPLE_LOG2;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;
  bit rx_calm = 1'b0;
  int rx_wait = 0;
  int mismatch_count = 0;

  logic [4:0]  osr_reg = 5'd8;
  logic [15:0] mcc_reg = 16'd255;
  logic [5:0]  pcnt_reg = 6'd4;
  logic [4:0]  base_reg = 5'd0;
  logic [31:0] chan_sum [4] = '{32'd0, 32'd0, 32'd0, 32'd0};
  logic [15:0] words_in_batch = 16'd0;
  logic [4:0]  scan_pin = 5'd0;
  reading_t due_readings [$];

  plan_row_t plan_rows [10] = '{
    // reset charge and pin settings, all-zero charge counts
    '{5'd4, 16'd255, 6'd4, 5'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
      16, 1'b0, 1'b1, 20'd4080},
    // flagged words, dropped
    '{5'd0, 16'd0, 6'd0, 5'd31, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      5, 1'b0, 1'b0, 20'd0},
    '{5'd0, 16'd0, 6'd0, 5'd31, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
      16, 1'b0, 1'b1, 20'd0},
    '{5'd3, 16'hFFFF, 6'd63, 5'd17, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0,
      16, 1'b0, 1'b1, 20'hFFFF0},
    // reading below zero
    '{5'd4, 16'd0, 6'd32, 5'd31, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16, 1'b0, 1'b1, 20'd0},
    '{5'd4, 16'hFFFF, 6'd32, 5'd31, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16, 1'b0, 1'b1, 20'd0},
    '{5'd4, 16'd4096, 6'd32, 5'd5, 1'b0, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
      16, 1'b0, 1'b0, 20'd0},
    // pin count lowered under a high active pin
    '{5'd4, 16'd4096, 6'd3, 5'd5, 1'b0, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0,
      16, 1'b0, 1'b0, 20'd0},
    // partial batch, then a lower oversampling ends it on the next word
    '{5'd6, 16'd4096, 6'd3, 5'd5, 1'b0, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
      40, 1'b0, 1'b0, 20'd0},
    '{5'd4, 16'd4096, 6'd3, 5'd5, 1'b0, 16'h0100, 16'h0200, 16'h0300, 16'h0400,
      1, 1'b0, 1'b0, 20'd0}
  };

  capacitive_scan_decimator dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned clamp_osr();
    int unsigned v;
    v = osr_reg;
    if (v < 4) v = 4;
    if (v > 16) v = 16;
    return v;
  endfunction

  function automatic int unsigned clamp_pins();
    int unsigned v;
    v = pcnt_reg;
    if (v == 0) v = 1;
    if (v > 32) v = 32;
    return v;
  endfunction

  function automatic logic [4:0] advance_pin(input logic [4:0] p);
    int unsigned pu;
    pu = p;
    if (pu >= clamp_pins() - 1) return 5'd0;
    return p + 5'd1;
  endfunction

  // Add one word to the channel sums; dump a batch of four readings when full.
  function automatic void accumulate_word(input logic [15:0] sa, input logic [15:0] sb,
                                          input logic [15:0] sc, input logic [15:0] sd,
                                          input bit fix_cap, input logic [19:0] cap);
    logic [15:0] smp [4];
    logic [4:0]  pins [4];
    logic [19:0] caps [4];
    logic [5:0]  gpio [4];
    logic [4:0]  p;
    int unsigned shift, top, sub;
    int i;
    reading_t r;
    smp[0] = sa;
    smp[1] = sb;
    smp[2] = sc;
    smp[3] = sd;
    for (i = 0; i < 4; i++) chan_sum[i] = chan_sum[i] + 32'(smp[i]);
    shift = clamp_osr();
    if (32'(words_in_batch) < (32'd1 << shift) - 32'd1) begin
      words_in_batch = words_in_batch + 16'd1;
      return;
    end
    top = 32'(mcc_reg) << 4;
    for (i = 0; i < 4; i++) begin
      sub = chan_sum[i] >> (shift - 4);
      caps[i] = (sub > top) ? 20'd0 : 20'(top - sub);
      pins[i] = scan_pin;
      chan_sum[i] = 32'd0;
      scan_pin = advance_pin(scan_pin);
    end
    words_in_batch = 16'd0;
    p = scan_pin;
    for (i = 0; i < 4; i++) begin
      gpio[i] = 6'(p) + 6'(base_reg);
      p = advance_pin(p);
    end
    for (i = 0; i < 4; i++) begin
      r.pin = pins[i];
      r.cap = fix_cap ? cap : caps[i];
      r.last = (i == 3);
      r.ga = gpio[0];
      r.gb = gpio[1];
      r.gc = gpio[2];
      r.gd = gpio[3];
      due_readings.push_back(r);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH at %0t: %s got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_reading(input logic [OUT_DATA_W-1:0] d, input logic tl);
    reading_t e;
    if (due_readings.size() == 0) begin
      flag_mismatch("unexpected word", 64'(d), 64'd0);
      return;
    end
    e = due_readings.pop_front();
    if (d[4:0] !== e.pin) flag_mismatch("pin_index", 64'(d[4:0]), 64'(e.pin));
    if (d[24:5] !== e.cap) flag_mismatch("cap_value", 64'(d[24:5]), 64'(e.cap));
    if (tl !== e.last) flag_mismatch("last", 64'(tl), 64'(e.last));
    if (d[30:25] !== e.ga) flag_mismatch("next_gpio_a", 64'(d[30:25]), 64'(e.ga));
    if (d[36:31] !== e.gb) flag_mismatch("next_gpio_b", 64'(d[36:31]), 64'(e.gb));
    if (d[42:37] !== e.gc) flag_mismatch("next_gpio_c", 64'(d[42:37]), 64'(e.gc));
    if (d[48:43] !== e.gd) flag_mismatch("next_gpio_d", 64'(d[48:43]), 64'(e.gd));
    if (d[55:49] !== 7'd0) flag_mismatch("zero fill", 64'(d[55:49]), 64'd0);
  endtask

  always @(posedge clk) begin : reading_sink
    int w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_reading(m_axis_tdata, m_axis_tlast);
      w = rx_calm ? 0 : $urandom_range(0, 12);
      rx_wait <= w;
      m_axis_tready <= (w == 0) && !rx_hold;
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait <= 0;
      m_axis_tready <= !rx_hold;
    end
  end

  // Hold the result stream off while the sender keeps streaming.
  initial begin
    @(posedge hold_go);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_OVERSAMPLE_LOG2:  osr_reg = val[4:0];
      CFG_MAX_CHARGE_COUNT: mcc_reg = val;
      CFG_SENSE_PIN_COUNT:  pcnt_reg = val[5:0];
      CFG_SENSE_PIN_BASE:   base_reg = val[4:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [4:0] osr, input logic [15:0] mcc,
                              input logic [5:0] pcnt, input logic [4:0] base);
    if (osr !== osr_reg) write_reg(CFG_OVERSAMPLE_LOG2, 16'(osr));
    if (mcc !== mcc_reg) write_reg(CFG_MAX_CHARGE_COUNT, mcc);
    if (pcnt !== pcnt_reg) write_reg(CFG_SENSE_PIN_COUNT, 16'(pcnt));
    if (base !== base_reg) write_reg(CFG_SENSE_PIN_BASE, 16'(base));
    cfg_we <= 1'b0;
  endtask

  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_word(input logic empty, input logic [15:0] sa, input logic [15:0] sb,
                           input logic [15:0] sc, input logic [15:0] sd, input bit no_gap,
                           input bit fix_cap, input logic [19:0] cap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= empty;
    s_axis_tdata <= {sd, sc, sb, sa};
    do @(posedge clk); while (!s_axis_tready);
    if (!empty) accumulate_word(sa, sb, sc, sd, fix_cap, cap);
  endtask

  initial begin : stimulus
    plan_row_t row;
    int k, phase_len, n_rand;
    bit first, calm;
    logic empty;
    logic [15:0] sa, sb, sc, sd, r_mcc;
    logic [4:0] r_osr, r_base;
    logic [5:0] r_pcnt;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_rows[r]) begin
      row = plan_rows[r];
      settle_idle();
      apply_config(row.osr, row.mcc, row.pcnt, row.base);
      rx_calm <= row.burst;
      for (k = 0; k < row.count; k++)
        send_word(row.empty, row.sa, row.sb, row.sc, row.sd, row.burst, row.has_cap,
                  row.cap);
    end

    n_rand = 0;
    first = 1'b1;
    while (n_rand < RAND_WORDS) begin
      settle_idle();
      if (first) r_osr = 5'd4;
      else if ($urandom_range(0, 7) == 0) r_osr = 5'($urandom_range(0, 3));
      else r_osr = 5'($urandom_range(4, 6));
      case ($urandom_range(0, 3))
        0: r_mcc = 16'd0;
        1: r_mcc = 16'hFFFF;
        default: r_mcc = 16'($urandom);
      endcase
      r_pcnt = 6'($urandom_range(0, 63));
      r_base = 5'($urandom_range(0, 31));
      apply_config(r_osr, r_mcc, r_pcnt, r_base);
      calm = first ? 1'b1 : ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      phase_len = first ? 120 : $urandom_range(20, 60);
      if (first) hold_go <= 1'b1;
      for (k = 0; k < phase_len; k++) begin
        empty = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 7))
          0: begin
            sa = 16'h0; sb = 16'h0; sc = 16'h0; sd = 16'h0;
          end
          1: begin
            sa = 16'hFFFF; sb = 16'hFFFF; sc = 16'hFFFF; sd = 16'hFFFF;
          end
          default: begin
            sa = 16'($urandom); sb = 16'($urandom);
            sc = 16'($urandom); sd = 16'($urandom);
          end
        endcase
        send_word(empty, sa, sb, sc, sd, calm, 1'b0, 20'd0);
        if (!empty) n_rand++;
        if (!first && $urandom_range(0, 39) == 0) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk); while (due_readings.size() != 0);
        end
      end
      first = 1'b0;
    end

    settle_idle();
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
